// File: rtl/core/stt_pkg.sv
// shared types, sizes and helpers for the scan timer table
// no dependencies; imported by every module of the block but the generic ram
package stt_pkg;

    localparam int DEPTH      = 32;
    localparam int TIME_BITS  = 64;
    localparam int VALUE_BITS = 32;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = TIME_BITS + VALUE_BITS;

    localparam int STAMP_W   = 64;
    localparam int PAYLOAD_W = 32;
    localparam int OCC_W     = 6;
    localparam int STAT_W    = 32;
    localparam int VWIDE_W   = (VALUE_BITS > PAYLOAD_W) ? VALUE_BITS : PAYLOAD_W;

    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_EXPIRE = 1'b1;

    typedef enum logic [2:0] {
        KIND_PUSH_OK   = 3'd0,
        KIND_PUSH_FULL = 3'd1,
        KIND_EXPIRED   = 3'd2,
        KIND_SKIPPED   = 3'd3,
        KIND_NONE      = 3'd4
    } kind_t;

    typedef struct packed {
        logic                 action;
        logic [STAMP_W-1:0]   time_stamp;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_item_t;

    typedef struct packed {
        kind_t                kind;
        logic [PAYLOAD_W-1:0] expired_value;
        logic                 last;
        logic [OCC_W-1:0]     occupancy;
        logic [OCC_W-1:0]     peak_occupancy;
        logic [STAT_W-1:0]    skips;
        logic [STAT_W-1:0]    empty_scans;
    } rsp_item_t;

    typedef struct packed {
        logic      valid;
        rsp_item_t item;
    } emit_t;

    function automatic logic [VALUE_BITS-1:0] to_value(input logic [PAYLOAD_W-1:0] p);
        logic [VWIDE_W-1:0] w;
        w = VWIDE_W'(p);
        return w[VALUE_BITS-1:0];
    endfunction

    function automatic logic [PAYLOAD_W-1:0] from_value(input logic [VALUE_BITS-1:0] v);
        logic [VWIDE_W-1:0] w;
        w = VWIDE_W'(v);
        return w[PAYLOAD_W-1:0];
    endfunction

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

endpackage

// File: rtl/core/stt_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/stt_out_reg.sv
// result output register with valid/stall handshake
// depends on stt_pkg
module stt_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  stt_pkg::emit_t    emit,
    output logic              free,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output stt_pkg::rsp_item_t rsp
);
    import stt_pkg::*;

    logic      valid_reg;
    rsp_item_t item_reg;

    assign free = !valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && emit.valid)
        begin
            item_reg <= emit.item;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = item_reg;

endmodule

// File: rtl/core/stt_scan.sv
// sequencer and shared compare unit: push, skip check and expiry scan
// depends on stt_pkg; drives the entry ram and the output register
module stt_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  stt_pkg::cmd_item_t             cmd,
    input  logic                           out_free,
    output stt_pkg::emit_t                 emit,
    output logic                           ram_we,
    output logic [stt_pkg::ADDR_W-1:0]     ram_waddr,
    output logic [stt_pkg::ENTRY_W-1:0]    ram_wdata,
    output logic [stt_pkg::ADDR_W-1:0]     ram_raddr,
    input  logic [stt_pkg::ENTRY_W-1:0]    ram_rdata
);
    import stt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_MOVE   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [TIME_BITS-1:0]  earliest_reg, earliest_next;
    logic [CNT_W-1:0]      peak_reg, peak_next;
    logic [STAT_W-1:0]     skips_reg, skips_next;
    logic [STAT_W-1:0]     empties_reg, empties_next;
    logic [TIME_BITS-1:0]  time_reg, time_next;
    logic                  pend_reg, pend_next;
    logic [VALUE_BITS-1:0] pend_value_reg, pend_value_next;
    logic [CNT_W-1:0]      pend_occ_reg, pend_occ_next;

    logic [TIME_BITS-1:0]  cmd_time;
    logic [TIME_BITS-1:0]  rd_deadline;
    logic [VALUE_BITS-1:0] rd_value;
    logic [TIME_BITS-1:0]  cmp_a, cmp_b;
    logic                  cmp_lt;
    logic                  earlier;
    logic [CNT_W-1:0]      idx_inc, count_dec, count_inc;
    logic                  accept;
    logic                  emit_valid, emit_pend, emit_last;
    kind_t                 emit_kind;

    assign cmd_time    = cmd.time_stamp[TIME_BITS-1:0];
    assign rd_deadline = ram_rdata[ENTRY_W-1 -: TIME_BITS];
    assign rd_value    = ram_rdata[VALUE_BITS-1:0];
    assign idx_inc     = idx_reg + 1'b1;
    assign count_dec   = count_reg - 1'b1;
    assign count_inc   = count_reg + 1'b1;

    // shared comparator: skip/lower check when idle, deadline check while scanning
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            cmp_a = cmd_time;
            cmp_b = earliest_reg;
        end
        else
        begin
            cmp_a = time_reg;
            cmp_b = rd_deadline;
        end
    end

    assign cmp_lt  = cmp_a < cmp_b;
    assign earlier = rd_deadline < earliest_reg;

    assign cmd_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        earliest_next   = earliest_reg;
        peak_next       = peak_reg;
        skips_next      = skips_reg;
        empties_next    = empties_reg;
        time_next       = time_reg;
        pend_next       = pend_reg;
        pend_value_next = pend_value_reg;
        pend_occ_next   = pend_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[ADDR_W-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[ADDR_W-1:0];
        emit_valid      = 1'b0;
        emit_pend       = 1'b0;
        emit_last       = 1'b1;
        emit_kind       = KIND_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_PUSH)
                    begin
                        emit_valid = 1'b1;
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            emit_kind = KIND_PUSH_FULL;
                        end
                        else
                        begin
                            emit_kind  = KIND_PUSH_OK;
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[ADDR_W-1:0];
                            ram_wdata  = {cmd_time, to_value(cmd.payload)};
                            count_next = count_inc;
                            if (count_inc > peak_reg)
                            begin
                                peak_next = count_inc;
                            end
                            if (cmp_lt)
                            begin
                                earliest_next = cmd_time;
                            end
                        end
                    end
                    else if (cmp_lt)
                    begin
                        emit_valid = 1'b1;
                        emit_kind  = KIND_SKIPPED;
                        skips_next = sat_inc(skips_reg);
                    end
                    else
                    begin
                        time_next     = cmd_time;
                        earliest_next = '1;
                        idx_next      = '0;
                        pend_next     = 1'b0;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CHECK:
            begin
                if (cmp_lt)
                begin
                    if (earlier)
                    begin
                        earliest_next = rd_deadline;
                    end
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[ADDR_W-1:0];
                    if (!(idx_inc < count_reg))
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        emit_valid = 1'b1;
                        emit_pend  = 1'b1;
                        emit_last  = 1'b0;
                        emit_kind  = KIND_EXPIRED;
                    end
                    pend_next       = 1'b1;
                    pend_value_next = rd_value;
                    pend_occ_next   = count_dec;
                    count_next      = count_dec;
                    ram_raddr       = count_dec[ADDR_W-1:0];
                    state_next      = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                // last entry fills the freed slot, then the slot is checked again
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[ADDR_W-1:0];
                ram_wdata  = ram_rdata;
                state_next = ST_READ;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    emit_valid = 1'b1;
                    if (pend_reg)
                    begin
                        emit_pend = 1'b1;
                        emit_kind = KIND_EXPIRED;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        emit_kind    = KIND_NONE;
                        empties_next = sat_inc(empties_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit.valid              = emit_valid;
        emit.item.kind          = emit_kind;
        emit.item.expired_value = emit_pend ? from_value(pend_value_reg) : '0;
        emit.item.last          = emit_last;
        emit.item.occupancy     = emit_pend ? OCC_W'(pend_occ_reg) : OCC_W'(count_next);
        emit.item.peak_occupancy = OCC_W'(peak_next);
        emit.item.skips         = skips_next;
        emit.item.empty_scans   = empties_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            earliest_reg <= '1;
            peak_reg     <= '0;
            skips_reg    <= '0;
            empties_reg  <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            earliest_reg <= earliest_next;
            peak_reg     <= peak_next;
            skips_reg    <= skips_next;
            empties_reg  <= empties_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg       <= time_next;
        pend_value_reg <= pend_value_next;
        pend_occ_reg   <= pend_occ_next;
    end

endmodule

// File: rtl/core/scan_timer_table_core.sv
// top level of the scan timer table
// depends on stt_pkg, stt_scan, stt_ram, stt_out_reg
//
// cmd channel (cmd_valid/cmd_stall/cmd) carries push and expire items;
// rsp channel (rsp_valid/rsp_stall/rsp) returns results, last marks the
// final result of an item. one item is worked on at a time: cmd_stall is
// low only while the sequencer is idle and the output register can load.
// push, rejected push and skipped expire: result is in the output
// register in the cycle after the transfer, next item may follow at once.
// an expire scan is paced by the single ram read port (one entry a
// cycle while entries do not expire, and each hit reads the last entry
// and writes it back into the freed slot).
// expired results are held one step so that last can be set on the final
// one. a stalled receiver freezes the scan at the next result.
// reset clears count, peak, counters and sets the earliest deadline to
// all ones; ram contents stay undefined and are never read before written.
module scan_timer_table_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  stt_pkg::cmd_item_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output stt_pkg::rsp_item_t rsp
);
    import stt_pkg::*;

    emit_t               emit;
    logic                out_free;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    stt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .out_free  (out_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    stt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stt_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// File: rtl/core/stt_checker.sv
// port level checks for the scan timer table, bound to the top level
// depends on stt_pkg and scan_timer_table_core
module stt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input stt_pkg::cmd_item_t cmd,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input stt_pkg::rsp_item_t rsp
);
    import stt_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind != KIND_EXPIRED) |-> rsp.expired_value == '0)
        else $error("value on a result that is not an expiry");

    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.kind == KIND_EXPIRED)
        else $error("only expiries may be followed by more results");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.peak_occupancy >= rsp.occupancy)
        else $error("occupancy above peak");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> cmd_stall)
        else $error("command taken while result blocked");

endmodule

bind scan_timer_table_core stt_checker u_stt_checker (.*);
